@@ hdl/bbs_pkg.sv @@
// ----------------------------------------------------------------------------
// bbs_pkg
// shared types and constants of the brownian bridge barrier survival block
// ----------------------------------------------------------------------------
package bbs_pkg;

    localparam int MAX_IMAGE_TERMS = 4;
    localparam int N_PAIR          = 2 * MAX_IMAGE_TERMS + 1;
    localparam int K_W             = $clog2(MAX_IMAGE_TERMS + 1);
    localparam int DIV_BITS        = 29;
    localparam int SERIES_DEGREE   = 9;
    localparam int LANE_LAT        = 3 + DIV_BITS + 2 + 2 * SERIES_DEGREE + 1;

    localparam logic [1:0] MODE_LOWER = 2'd0;
    localparam logic [1:0] MODE_UPPER = 2'd1;

    localparam logic [1:0] REG_MODE  = 2'd0;
    localparam logic [1:0] REG_LOWER = 2'd1;
    localparam logic [1:0] REG_UPPER = 2'd2;
    localparam logic [1:0] REG_TERMS = 2'd3;

    localparam logic [30:0] Q30_ONE   = 31'h4000_0000;
    localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
    localparam logic [29:0] LN2_Q30   = 30'd744261118;
    localparam logic [16:0] SURV_ONE  = 17'd65536;

    // ceil(2^35 / k), exact floor division for 31-bit values
    // k = 1 passes the term straight through, so its entry is unused
    localparam logic [34:0] RECIP_Q35 [1:SERIES_DEGREE] = '{
        35'd0,           35'd17179869184, 35'd11453246123,
        35'd8589934592,  35'd6871947674,  35'd5726623062,
        35'd4908534053,  35'd4294967296,  35'd3817748708
    };

    typedef struct packed {
        logic signed [31:0] start_log_price;
        logic signed [31:0] end_log_price;
        logic signed [31:0] step_variance;
    } t_bbs_in;

    typedef struct packed {
        logic [16:0] survival;
        logic        status;
    } t_bbs_out;

    typedef struct packed {
        logic           valid;
        logic           fix;
        logic [16:0]    fix_val;
        logic           status;
        logic           dbl;
        logic [K_W-1:0] k;
    } t_bbs_ctl;

endpackage

@@ hdl/bbs_exp_lane.sv @@
// ----------------------------------------------------------------------------
// bbs_exp_lane
// pipelined exp(-2*m1*m2/v) in q30: split multiply, restoring divide,
// base-2 range reduction and a degree-nine series
// ----------------------------------------------------------------------------
module bbs_exp_lane import bbs_pkg::*; (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [34:0] i_m1,
    input  logic [34:0] i_m2,
    input  logic [30:0] i_v,
    output logic [30:0] o_exp
);

    localparam int REM_W = 31 + DIV_BITS;

    logic [52:0] r_pp_lo;
    logic [51:0] r_pp_hi;
    logic [30:0] r_v1;
    logic [69:0] r_p;
    logic [30:0] r_v2;

    logic [REM_W-1:0]    r_rem   [0:DIV_BITS-1];
    logic [DIV_BITS-1:0] r_quo   [0:DIV_BITS];
    logic [30:0]         r_dv    [0:DIV_BITS-1];
    logic                r_dover [0:DIV_BITS];

    logic [30:0] r_t;
    logic        r_e1_over;
    logic [60:0] w_tprod;
    logic [53:0] w_rprod;

    logic [30:0] r_tb_term [0:SERIES_DEGREE-1];
    logic [31:0] r_tb_even [0:SERIES_DEGREE];
    logic [31:0] r_tb_odd  [0:SERIES_DEGREE];
    logic [6:0]  r_tb_n    [0:SERIES_DEGREE];
    logic [29:0] r_tb_r    [0:SERIES_DEGREE-1];
    logic        r_tb_over [0:SERIES_DEGREE];

    logic [30:0] r_ta_y    [1:SERIES_DEGREE];
    logic [31:0] r_ta_even [1:SERIES_DEGREE];
    logic [31:0] r_ta_odd  [1:SERIES_DEGREE];
    logic [6:0]  r_ta_n    [1:SERIES_DEGREE];
    logic [29:0] r_ta_r    [1:SERIES_DEGREE];
    logic        r_ta_over [1:SERIES_DEGREE];

    logic [31:0] w_diff;
    logic [31:0] w_shift;

    // product in two partial products, then the overflow test
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pp_lo    <= 53'(i_m1[17:0]) * 53'(i_m2);
            r_pp_hi    <= 52'(i_m1[34:18]) * 52'(i_m2);
            r_v1       <= i_v;
            r_p        <= 70'(r_pp_lo) + {r_pp_hi, 18'b0};
            r_v2       <= r_v1;
            r_dover[0] <= r_p >= 70'({r_v2, {DIV_BITS{1'b0}}});
            r_rem[0]   <= r_p[REM_W-1:0];
            r_quo[0]   <= '0;
            r_dv[0]    <= r_v2;
        end
    end

    // one quotient bit per stage
    for (genvar j = 0; j < DIV_BITS; j++) begin : g_div
        localparam int SH = DIV_BITS - 1 - j;
        logic [REM_W-1:0] w_sub;
        logic             w_ge;
        assign w_sub = REM_W'(r_dv[j]) << SH;
        assign w_ge  = r_rem[j] >= w_sub;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_quo[j+1]   <= {r_quo[j][DIV_BITS-2:0], w_ge};
                r_dover[j+1] <= r_dover[j];
            end
        end
        if (j < DIV_BITS - 1) begin : g_keep
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[j+1] <= w_ge ? r_rem[j] - w_sub : r_rem[j];
                    r_dv[j+1]  <= r_dv[j];
                end
            end
        end
    end

    assign w_tprod = 61'({r_quo[DIV_BITS], 1'b0}) * 61'(LOG2E_Q30);
    assign w_rprod = 54'(r_t[23:0]) * 54'(LN2_Q30);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_t          <= w_tprod[60:30];
            r_e1_over    <= r_dover[DIV_BITS];
            r_tb_term[0] <= Q30_ONE;
            r_tb_even[0] <= 32'(Q30_ONE);
            r_tb_odd[0]  <= '0;
            r_tb_n[0]    <= r_t[30:24];
            r_tb_r[0]    <= w_rprod[53:24];
            r_tb_over[0] <= r_e1_over;
        end
    end

    // series terms: multiply by r, then divide by k
    for (genvar k = 1; k <= SERIES_DEGREE; k++) begin : g_term
        logic [60:0] w_mul;
        logic [65:0] w_div;
        logic [30:0] w_term;
        assign w_mul  = 61'(r_tb_term[k-1]) * 61'(r_tb_r[k-1]);
        assign w_div  = 66'(r_ta_y[k]) * 66'(RECIP_Q35[k]);
        assign w_term = (k == 1) ? r_ta_y[k] : w_div[65:35];
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_ta_y[k]    <= w_mul[60:30];
                r_ta_even[k] <= r_tb_even[k-1];
                r_ta_odd[k]  <= r_tb_odd[k-1];
                r_ta_n[k]    <= r_tb_n[k-1];
                r_ta_r[k]    <= r_tb_r[k-1];
                r_ta_over[k] <= r_tb_over[k-1];
                if (k % 2 == 1) begin
                    r_tb_odd[k]  <= r_ta_odd[k] + 32'(w_term);
                    r_tb_even[k] <= r_ta_even[k];
                end else begin
                    r_tb_even[k] <= r_ta_even[k] + 32'(w_term);
                    r_tb_odd[k]  <= r_ta_odd[k];
                end
                r_tb_n[k]    <= r_ta_n[k];
                r_tb_over[k] <= r_ta_over[k];
            end
        end
        if (k < SERIES_DEGREE) begin : g_keep
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_tb_term[k] <= w_term;
                    r_tb_r[k]    <= r_ta_r[k];
                end
            end
        end
    end

    assign w_diff  = r_tb_even[SERIES_DEGREE] - r_tb_odd[SERIES_DEGREE];
    assign w_shift = w_diff >> r_tb_n[SERIES_DEGREE];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_tb_over[SERIES_DEGREE] || r_tb_n[SERIES_DEGREE] >= 7'd31) begin
                o_exp <= '0;
            end else begin
                o_exp <= w_shift[30:0];
            end
        end
    end

endmodule

@@ hdl/bridge_barrier_survival_top.sv @@
// ----------------------------------------------------------------------------
// bridge_barrier_survival_top
// survival probability of a brownian bridge against one or two barriers
// ----------------------------------------------------------------------------
// channel   direction  handshake                   payload
// in        input      i_in_valid / o_in_ready     i_in_data (t_bbs_in)
// out       output     o_out_valid / i_out_ready   o_out_data (t_bbs_out)
// cfg       input      i_cfg_we                    i_cfg_index, i_cfg_data
//
// one item per cycle while the output queue is not full
// each lane pipe holds a 29-stage divider and an 18-stage series
// eighteen exp lanes run side by side, two per image term
// a two-entry output queue lets items enter while a result waits
// the whole pipe holds when the queue is full; nothing is lost
// synchronous active-low reset clears valid and control bits, queue count and config registers
module bridge_barrier_survival_top import bbs_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_bbs_in     i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_bbs_out    o_out_data,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    localparam int N_GRP = (N_PAIR + 2) / 3;

    logic [1:0]        r_mode;
    logic signed [31:0] r_lower;
    logic signed [31:0] r_upper;
    logic [3:0]        r_terms;

    logic w_en;

    // front stage signals
    logic signed [32:0] w_s, w_e, w_lo, w_up;
    logic signed [32:0] w_a_lo, w_b_lo, w_a_up, w_b_up;
    logic signed [31:0] w_v;
    logic               w_single;
    logic               w_bad;
    t_bbs_ctl           w_ctl1;

    t_bbs_ctl           r1_ctl;
    logic signed [32:0] r1_a, r1_b, r1_w, r1_d;
    logic [30:0]        r1_v;

    t_bbs_ctl    r2_ctl;
    logic [30:0] r2_v;
    logic [34:0] r2_dm1 [0:N_PAIR-1];
    logic [34:0] r2_dm2 [0:N_PAIR-1];
    logic [34:0] r2_rm1 [0:N_PAIR-1];
    logic [34:0] r2_rm2 [0:N_PAIR-1];

    logic [30:0] w_dir [0:N_PAIR-1];
    logic [30:0] w_ref [0:N_PAIR-1];

    t_bbs_ctl r_dly [0:LANE_LAT-1];

    t_bbs_ctl           r3_ctl, r4_ctl, r5_ctl;
    logic signed [34:0] r3_c   [0:N_PAIR-1];
    logic [30:0]        r3_ref0, r4_ref0, r5_ref0;
    logic signed [34:0] w_grp  [0:N_GRP-1];
    logic signed [34:0] r4_grp [0:N_GRP-1];
    logic signed [34:0] w_tot;
    logic signed [34:0] r5_tot;

    logic     r6_valid;
    t_bbs_out r6_out;
    t_bbs_out w_out;

    t_bbs_out r_fq [0:1];
    logic [1:0] r_cnt;
    logic       w_push, w_pop;
    logic [1:0] w_slot;

    function automatic logic [34:0] mag35(input logic signed [35:0] x);
        logic signed [35:0] y;
        y = (x < 0) ? -x : x;
        return y[34:0];
    endfunction

    function automatic logic [16:0] q30_to_q16(input logic signed [34:0] s);
        logic [30:0] c;
        logic [31:0] t;
        if (s < 0) begin
            c = '0;
        end else if (s > 35'sd1073741824) begin
            c = Q30_ONE;
        end else begin
            c = s[30:0];
        end
        t = 32'(c) + 32'd8192;
        return t[30:14];
    endfunction

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_LOWER;
            r_lower <= '0;
            r_upper <= '0;
            r_terms <= 4'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_MODE:  r_mode  <= i_cfg_data[1:0];
                REG_LOWER: r_lower <= i_cfg_data;
                REG_UPPER: r_upper <= i_cfg_data;
                REG_TERMS: r_terms <= i_cfg_data[3:0];
                default:   r_mode  <= r_mode;
            endcase
        end
    end

    assign w_en       = (r_cnt != 2'd2);
    assign o_in_ready = w_en;

    // stage 1: endpoint distances and the fixed-result cases
    assign w_s    = {i_in_data.start_log_price[31], i_in_data.start_log_price};
    assign w_e    = {i_in_data.end_log_price[31], i_in_data.end_log_price};
    assign w_v    = i_in_data.step_variance;
    assign w_lo   = {r_lower[31], r_lower};
    assign w_up   = {r_upper[31], r_upper};
    assign w_a_lo = w_s - w_lo;
    assign w_b_lo = w_e - w_lo;
    assign w_a_up = w_up - w_s;
    assign w_b_up = w_up - w_e;
    assign w_single = (r_mode == MODE_LOWER) || (r_mode == MODE_UPPER);
    assign w_bad  = (r_mode == MODE_UPPER) ? (w_a_up <= 0 || w_b_up <= 0)
                                           : (w_a_lo <= 0 || w_b_lo <= 0);

    always_comb begin
        w_ctl1         = '0;
        w_ctl1.valid   = i_in_valid;
        w_ctl1.dbl     = !w_single;
        if (r_terms == 4'd0) begin
            w_ctl1.k = K_W'(1);
        end else if (r_terms > 4'(MAX_IMAGE_TERMS)) begin
            w_ctl1.k = K_W'(MAX_IMAGE_TERMS);
        end else begin
            w_ctl1.k = r_terms[K_W-1:0];
        end
        if (w_single) begin
            if (w_bad) begin
                w_ctl1.fix = 1'b1;
            end else if (w_v <= 0) begin
                w_ctl1.fix     = 1'b1;
                w_ctl1.fix_val = SURV_ONE;
            end
        end else if (r_lower >= r_upper) begin
            w_ctl1.fix    = 1'b1;
            w_ctl1.status = 1'b1;
        end else if (w_a_lo <= 0 || w_b_lo <= 0 || w_a_up <= 0 || w_b_up <= 0) begin
            w_ctl1.fix = 1'b1;
        end else if (w_v <= 0) begin
            w_ctl1.fix     = 1'b1;
            w_ctl1.fix_val = SURV_ONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_ctl <= '0;
        end else if (w_en) begin
            r1_ctl <= w_ctl1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_a <= (r_mode == MODE_UPPER) ? w_a_up : w_a_lo;
            r1_b <= (r_mode == MODE_UPPER) ? w_b_up : w_b_lo;
            r1_w <= w_up - w_lo;
            r1_d <= w_e - w_s;
            r1_v <= w_v[30:0];
        end
    end

    // stage 2: image-term magnitudes, then the exp lanes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_ctl <= '0;
        end else if (w_en) begin
            r2_ctl <= r1_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_v <= r1_v;
        end
    end

    for (genvar i = 0; i < N_PAIR; i++) begin : g_pair
        localparam int KV = i - MAX_IMAGE_TERMS;
        logic signed [35:0] w_w36, w_kw, w_d36, w_a36, w_b36;
        assign w_w36 = {{3{r1_w[32]}}, r1_w};
        assign w_d36 = {{3{r1_d[32]}}, r1_d};
        assign w_a36 = {{3{r1_a[32]}}, r1_a};
        assign w_b36 = {{3{r1_b[32]}}, r1_b};
        assign w_kw  = w_w36 * 36'(KV);

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r2_dm1[i] <= mag35(w_kw);
                r2_dm2[i] <= mag35(w_kw + w_d36);
                r2_rm1[i] <= mag35(w_a36 + w_kw);
                r2_rm2[i] <= mag35(w_b36 + w_kw);
            end
        end

        bbs_exp_lane u_dir (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_m1  (r2_dm1[i]),
            .i_m2  (r2_dm2[i]),
            .i_v   (r2_v),
            .o_exp (w_dir[i])
        );

        bbs_exp_lane u_ref (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_m1  (r2_rm1[i]),
            .i_m2  (r2_rm2[i]),
            .i_v   (r2_v),
            .o_exp (w_ref[i])
        );

        localparam int KABS = (KV < 0) ? -KV : KV;
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                if (K_W'(KABS) <= r_dly[LANE_LAT-1].k) begin
                    r3_c[i] <= $signed({4'b0, w_dir[i]}) - $signed({4'b0, w_ref[i]});
                end else begin
                    r3_c[i] <= '0;
                end
            end
        end
    end

    // control travels beside the lanes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < LANE_LAT; j++) begin
                r_dly[j] <= '0;
            end
            r3_ctl <= '0;
            r4_ctl <= '0;
            r5_ctl <= '0;
        end else if (w_en) begin
            r_dly[0] <= r2_ctl;
            for (int j = 1; j < LANE_LAT; j++) begin
                r_dly[j] <= r_dly[j-1];
            end
            r3_ctl <= r_dly[LANE_LAT-1];
            r4_ctl <= r3_ctl;
            r5_ctl <= r4_ctl;
        end
    end

    // sum of the image terms
    always_comb begin
        for (int g = 0; g < N_GRP; g++) begin
            w_grp[g] = '0;
            for (int m = 0; m < 3; m++) begin
                if (3 * g + m < N_PAIR) begin
                    w_grp[g] = w_grp[g] + r3_c[3 * g + m];
                end
            end
        end
        w_tot = '0;
        for (int g = 0; g < N_GRP; g++) begin
            w_tot = w_tot + r4_grp[g];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_ref0 <= w_ref[MAX_IMAGE_TERMS];
            r4_ref0 <= r3_ref0;
            r5_ref0 <= r4_ref0;
            for (int g = 0; g < N_GRP; g++) begin
                r4_grp[g] <= w_grp[g];
            end
            r5_tot <= w_tot;
        end
    end

    // final rounding
    always_comb begin
        w_out.status = r5_ctl.status;
        if (r5_ctl.fix) begin
            w_out.survival = r5_ctl.fix_val;
        end else if (r5_ctl.dbl) begin
            w_out.survival = q30_to_q16(r5_tot);
        end else begin
            w_out.survival = q30_to_q16($signed(35'(Q30_ONE)) - $signed({4'b0, r5_ref0}));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_valid <= 1'b0;
        end else if (w_en) begin
            r6_valid <= r5_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r6_out <= w_out;
        end
    end

    // output queue
    assign w_pop  = (r_cnt != 2'd0) && i_out_ready;
    assign w_push = w_en && r6_valid;
    assign w_slot = r_cnt - {1'b0, w_pop};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push && !w_slot[0]) begin
            r_fq[0] <= r6_out;
        end else if (w_pop) begin
            r_fq[0] <= r_fq[1];
        end
        if (w_push && w_slot[0]) begin
            r_fq[1] <= r6_out;
        end
    end

    assign o_out_valid = (r_cnt != 2'd0);
    assign o_out_data  = r_fq[0];

endmodule
